/* hdl/rcfe_pkg.sv */
// Shared types, constants and helper functions for the receiver command frame encoder.
package rcfe_pkg;

    // Frame layout constants
    localparam logic [7:0] RCFE_START     = 8'hAA;
    localparam logic [7:0] RCFE_ADDR      = 8'hFF;
    localparam logic [7:0] RCFE_ESC       = 8'h5A;
    localparam int         RCFE_SLOTS     = 7;
    localparam int         RCFE_SLOT_W    = $clog2(RCFE_SLOTS);
    localparam int         RCFE_QUEUE_DEPTH = 2;

    // Special byte values and their escape codes
    localparam logic [7:0] RCFE_SPC_5A = 8'h5A;
    localparam logic [7:0] RCFE_SPC_55 = 8'h55;
    localparam logic [7:0] RCFE_SPC_A5 = 8'hA5;
    localparam logic [7:0] RCFE_SPC_AA = 8'hAA;
    localparam logic [7:0] RCFE_CODE_5A = 8'h00;
    localparam logic [7:0] RCFE_CODE_55 = 8'h01;
    localparam logic [7:0] RCFE_CODE_A5 = 8'h02;
    localparam logic [7:0] RCFE_CODE_AA = 8'h03;

    // Command kinds
    typedef enum logic [2:0] {
        KIND_SET_FREQ  = 3'd0,
        KIND_GET_FREQ  = 3'd1,
        KIND_SET_ATT1  = 3'd2,
        KIND_SET_ATT2  = 3'd3,
        KIND_SET_FILT  = 3'd4
    } t_kind;

    // Size and type bytes per kind
    localparam logic [7:0] SIZE_FREQ = 8'd3;
    localparam logic [7:0] SIZE_GET  = 8'd1;
    localparam logic [7:0] SIZE_BYTE = 8'd2;
    localparam logic [7:0] TYPE_SET_FREQ = 8'd2;
    localparam logic [7:0] TYPE_GET_FREQ = 8'd4;
    localparam logic [7:0] TYPE_SET_ATT1 = 8'd3;
    localparam logic [7:0] TYPE_SET_ATT2 = 8'd7;
    localparam logic [7:0] TYPE_SET_FILT = 8'd6;

    // Input request
    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] value;
    } t_cmd_in;

    // Output request
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_frame_out;

    // Classified frame: unstuffed bytes, which ones get stuffed, final slot
    typedef struct packed {
        logic [RCFE_SLOTS-1:0][7:0] slot;
        logic [RCFE_SLOTS-1:0]      stuff;
        logic [RCFE_SLOT_W-1:0]     last_slot;
    } t_frame_desc;

    // Queue write port from front to queue
    typedef struct packed {
        logic        wr_en;
        t_frame_desc desc;
    } t_desc_wr;

    function automatic logic is_special(input logic [7:0] b);
        is_special = (b == RCFE_SPC_5A) || (b == RCFE_SPC_55) ||
                     (b == RCFE_SPC_A5) || (b == RCFE_SPC_AA);
    endfunction

    function automatic logic [7:0] esc_code(input logic [7:0] b);
        logic [7:0] c;
        c = RCFE_CODE_5A;
        if (b == RCFE_SPC_55) begin
            c = RCFE_CODE_55;
        end else if (b == RCFE_SPC_A5) begin
            c = RCFE_CODE_A5;
        end else if (b == RCFE_SPC_AA) begin
            c = RCFE_CODE_AA;
        end
        esc_code = c;
    endfunction

endpackage

/* hdl/rcfe_front.sv */
// Front end: classifies each command request into a frame descriptor.
module rcfe_front
    import rcfe_pkg::*;
(
    input  logic     i_push,
    input  t_cmd_in  i_cmd,
    input  logic     i_q_full,
    output t_desc_wr o_wr
);

    logic [7:0] w_hi;
    logic [7:0] w_lo;
    logic [7:0] w_crc;
    logic       w_known;

    assign w_hi = i_cmd.value[15:8];
    assign w_lo = i_cmd.value[7:0];

    // Build the descriptor; drop unknown kinds
    always_comb begin
        w_known        = 1'b1;
        w_crc          = 8'd0;
        o_wr.desc      = '0;
        o_wr.desc.slot[0] = RCFE_START;
        o_wr.desc.slot[1] = RCFE_ADDR;
        unique case (i_cmd.kind)
            KIND_SET_FREQ: begin
                w_crc = RCFE_ADDR + SIZE_FREQ + TYPE_SET_FREQ + w_hi + w_lo + 8'd1;
                o_wr.desc.slot[2]  = SIZE_FREQ;
                o_wr.desc.slot[3]  = TYPE_SET_FREQ;
                o_wr.desc.slot[4]  = w_hi;
                o_wr.desc.slot[5]  = w_lo;
                o_wr.desc.slot[6]  = w_crc;
                o_wr.desc.stuff[4] = 1'b1;
                o_wr.desc.stuff[5] = 1'b1;
                o_wr.desc.stuff[6] = 1'b1;
                o_wr.desc.last_slot = RCFE_SLOT_W'(6);
            end
            KIND_GET_FREQ: begin
                w_crc = RCFE_ADDR + SIZE_GET + TYPE_GET_FREQ + 8'd1;
                o_wr.desc.slot[2]  = SIZE_GET;
                o_wr.desc.slot[3]  = TYPE_GET_FREQ;
                o_wr.desc.slot[4]  = w_crc;
                o_wr.desc.last_slot = RCFE_SLOT_W'(4);
            end
            KIND_SET_ATT1, KIND_SET_ATT2, KIND_SET_FILT: begin
                o_wr.desc.slot[2] = SIZE_BYTE;
                if (i_cmd.kind == KIND_SET_ATT1) begin
                    o_wr.desc.slot[3] = TYPE_SET_ATT1;
                end else if (i_cmd.kind == KIND_SET_ATT2) begin
                    o_wr.desc.slot[3] = TYPE_SET_ATT2;
                end else begin
                    o_wr.desc.slot[3] = TYPE_SET_FILT;
                end
                w_crc = RCFE_ADDR + SIZE_BYTE + o_wr.desc.slot[3] + w_lo + 8'd1;
                o_wr.desc.slot[4]  = w_lo;
                o_wr.desc.slot[5]  = w_crc;
                o_wr.desc.stuff[5] = 1'b1;
                o_wr.desc.last_slot = RCFE_SLOT_W'(5);
            end
            default: begin
                w_known = 1'b0;
            end
        endcase
        o_wr.wr_en = i_push && !i_q_full && w_known;
    end

endmodule

/* hdl/rcfe_queue.sv */
// Short descriptor queue between front end and byte sequencer.
module rcfe_queue
    import rcfe_pkg::*;
#(
    parameter int DEPTH = RCFE_QUEUE_DEPTH
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_desc_wr    i_wr,
    input  logic        i_rd_en,
    output logic        o_full,
    output logic        o_rd_valid,
    output t_frame_desc o_rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_frame_desc        r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wptr, n_wptr;
    logic [PTR_W-1:0]   r_rptr, n_rptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               w_do_wr, w_do_rd;

    assign o_full     = (r_count == CNT_W'(DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rptr];
    assign w_do_wr    = i_wr.wr_en && !o_full;
    assign w_do_rd    = i_rd_en && o_rd_valid;

    // Advance pointers and count
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (w_do_wr) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_wptr + PTR_W'(1));
        end
        if (w_do_rd) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_rptr + PTR_W'(1));
        end
        if (w_do_wr && !w_do_rd) begin
            n_count = CNT_W'(r_count + CNT_W'(1));
        end else if (!w_do_wr && w_do_rd) begin
            n_count = CNT_W'(r_count - CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (w_do_wr) begin
            r_mem[r_wptr] <= i_wr.desc;
        end
    end

endmodule

/* hdl/rcfe_back.sv */
// Back end: walks a descriptor, inserts escapes and drives the output register.
module rcfe_back
    import rcfe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_frame_desc i_desc,
    output logic        o_q_pop,
    input  logic        i_pop,
    output logic        o_empty,
    output t_frame_out  o_frame
);

    logic [RCFE_SLOT_W-1:0] r_idx, n_idx;
    logic                   r_esc, n_esc;
    logic                   r_out_valid, n_out_valid;
    t_frame_out             r_out, n_out;
    logic [7:0]             w_cur;
    logic                   w_needs_esc;
    logic                   w_last;
    logic                   w_emit;

    assign w_cur       = i_desc.slot[r_idx];
    assign w_needs_esc = i_desc.stuff[r_idx] && is_special(w_cur);
    assign w_last      = (r_idx == i_desc.last_slot) && (!w_needs_esc || r_esc);
    assign w_emit      = i_q_valid && (!r_out_valid || i_pop);
    assign o_q_pop     = w_emit && w_last;
    assign o_empty     = !r_out_valid;
    assign o_frame     = r_out;

    // Pick the next byte and advance the slot walk
    always_comb begin
        n_idx       = r_idx;
        n_esc       = r_esc;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (w_emit) begin
            n_out_valid      = 1'b1;
            n_out.last_byte  = w_last;
            if (w_needs_esc && !r_esc) begin
                n_out.frame_byte = RCFE_ESC;
                n_esc            = 1'b1;
            end else begin
                n_out.frame_byte = w_needs_esc ? esc_code(w_cur) : w_cur;
                n_esc            = 1'b0;
                n_idx            = w_last ? '0 : RCFE_SLOT_W'(r_idx + RCFE_SLOT_W'(1));
            end
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_esc       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_esc       <= n_esc;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold output payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

/* hdl/receiver_command_frame_encoder.sv */
// Top level of the receiver command frame encoder.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------
//  command  | in        | push / full        | i_cmd   (kind, value)
//  frame    | out       | empty / pop        | o_frame (frame_byte, last_byte)
//
// One frame byte leaves per cycle while pop is held; each frame, 5 to 10 bytes
// long, comes from the single byte sequencer in the back end.
// When all is idle, the first frame byte of an accepted command passes through
// the descriptor queue and then the output register before it shows on the output.
// Commands of unknown kind are accepted and dropped without any output.
// The descriptor queue lets the front take new commands while the back stalls.
// Reset is synchronous, active low, and empties queue and output register.
module receiver_command_frame_encoder
    import rcfe_pkg::*;
#(
    parameter int QUEUE_DEPTH = RCFE_QUEUE_DEPTH
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  t_cmd_in    i_cmd,
    output logic       empty,
    input  logic       pop,
    output t_frame_out o_frame
);

    t_desc_wr    w_wr;
    logic        w_q_full;
    logic        w_q_valid;
    logic        w_q_pop;
    t_frame_desc w_q_data;

    assign full = w_q_full;

    // Classify requests
    rcfe_front u_front (
        .i_push   (push),
        .i_cmd    (i_cmd),
        .i_q_full (w_q_full),
        .o_wr     (w_wr)
    );

    // Buffer descriptors
    rcfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (w_wr),
        .i_rd_en    (w_q_pop),
        .o_full     (w_q_full),
        .o_rd_valid (w_q_valid),
        .o_rd_data  (w_q_data)
    );

    // Emit frame bytes
    rcfe_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_desc    (w_q_data),
        .o_q_pop   (w_q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_frame   (o_frame)
    );

endmodule

/* hdl/rcfe_checker.sv */
// Port-level checker for the receiver command frame encoder, with its bind.
module rcfe_checker
    import rcfe_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input t_frame_out o_frame
);

    logic       r_mid;
    logic [3:0] r_cnt;
    logic       w_take;

    assign w_take = pop && !empty;

    // Track position inside the current frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid <= 1'b0;
            r_cnt <= '0;
        end else if (w_take) begin
            if (o_frame.last_byte) begin
                r_mid <= 1'b0;
                r_cnt <= '0;
            end else begin
                r_mid <= 1'b1;
                r_cnt <= (r_cnt == 4'd15) ? r_cnt : 4'(r_cnt + 4'd1);
            end
        end
    end

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("queue or output not cleared by reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_frame)))
        else $error("stalled result changed");

    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !r_mid) |-> (o_frame.frame_byte == RCFE_START))
        else $error("frame does not open with start byte");

    a_min_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && r_cnt < 4'd4) |-> !o_frame.last_byte)
        else $error("frame shorter than five bytes");

    a_max_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && r_cnt == 4'd9) |-> o_frame.last_byte)
        else $error("frame longer than ten bytes");

endmodule

bind receiver_command_frame_encoder rcfe_checker u_rcfe_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .o_frame (o_frame)
);

/* tb/sv/receiver_command_frame_encoder_test.sv */
// Self-checking testbench for the receiver command frame encoder.
module receiver_command_frame_encoder_test
    import rcfe_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam time CLK_PERIOD    = 8ns;
    localparam int  RESET_CYCLES  = 9;
    localparam int  RANDOM_CMDS   = 200;
    localparam int  STEADY_FIRST  = 60;
    localparam int  STEADY_LAST   = 100;
    localparam int  PRESSURE_AT   = 150;
    localparam int  PRESSURE_HOLD = 300;
    localparam int  DRAIN_CYCLES  = 16;
    localparam int  QUIET_LIMIT   = 2000;

    // Kinds outside the command set; the block drops them
    localparam logic [2:0] KIND_UNUSED_5 = 3'd5;
    localparam logic [2:0] KIND_UNUSED_6 = 3'd6;
    localparam logic [2:0] KIND_UNUSED_7 = 3'd7;

    // Directed row: a command, and its frame where it is typed in by hand
    typedef struct packed {
        t_cmd_in     cmd;
        logic        typed;
        logic [3:0]  nbytes;
        logic [79:0] bytes;     // first frame byte in the top octet
    } t_dir_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       push;
    logic       full;
    t_cmd_in    i_cmd;
    logic       empty;
    logic       pop;
    t_frame_out o_frame;

    t_frame_out frame_q[$];     // frame bytes still owed by the block
    t_dir_row   dir_rows[$];
    int         error_count   = 0;
    int         accepted_cmds = 0;
    int         quiet_cycles  = 0;
    bit         steady        = 1'b0;
    t_frame_out want;

    receiver_command_frame_encoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_cmd   (i_cmd),
        .empty   (empty),
        .pop     (pop),
        .o_frame (o_frame)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    // Pick a gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] special_byte();
        case ($urandom_range(0, 3))
            0: return RCFE_SPC_5A;
            1: return RCFE_SPC_55;
            2: return RCFE_SPC_A5;
            default: return RCFE_SPC_AA;
        endcase
    endfunction

    // Look up size and type bytes; return 0 for a kind with no frame
    function automatic bit kind_bytes(input logic [2:0] kind, output logic [7:0] size_b,
                                      output logic [7:0] type_b);
        size_b = SIZE_BYTE;
        type_b = '0;
        kind_bytes = 1'b1;
        case (kind)
            KIND_SET_FREQ: begin
                size_b = SIZE_FREQ;
                type_b = TYPE_SET_FREQ;
            end
            KIND_GET_FREQ: begin
                size_b = SIZE_GET;
                type_b = TYPE_GET_FREQ;
            end
            KIND_SET_ATT1: type_b = TYPE_SET_ATT1;
            KIND_SET_ATT2: type_b = TYPE_SET_ATT2;
            KIND_SET_FILT: type_b = TYPE_SET_FILT;
            default: kind_bytes = 1'b0;
        endcase
    endfunction

    function automatic void queue_frame_byte(input logic [7:0] b);
        t_frame_out f;
        f.frame_byte = b;
        f.last_byte  = 1'b0;
        frame_q.push_back(f);
    endfunction

    // Escape the four reserved values as the escape byte plus a code
    function automatic void queue_stuffed_byte(input logic [7:0] b);
        case (b)
            RCFE_SPC_5A: begin
                queue_frame_byte(RCFE_ESC);
                queue_frame_byte(RCFE_CODE_5A);
            end
            RCFE_SPC_55: begin
                queue_frame_byte(RCFE_ESC);
                queue_frame_byte(RCFE_CODE_55);
            end
            RCFE_SPC_A5: begin
                queue_frame_byte(RCFE_ESC);
                queue_frame_byte(RCFE_CODE_A5);
            end
            RCFE_SPC_AA: begin
                queue_frame_byte(RCFE_ESC);
                queue_frame_byte(RCFE_CODE_AA);
            end
            default: queue_frame_byte(b);
        endcase
    endfunction

    // Encode one command and append its frame to the owed bytes
    function automatic void expect_frame(input t_cmd_in cmd);
        logic [7:0] size_b, type_b, sum, hi, lo;
        t_frame_out tail;
        if (!kind_bytes(cmd.kind, size_b, type_b)) begin
            return;
        end
        hi  = cmd.value[15:8];
        lo  = cmd.value[7:0];
        sum = RCFE_ADDR + size_b + type_b + 8'd1;
        queue_frame_byte(RCFE_START);
        queue_frame_byte(RCFE_ADDR);
        queue_frame_byte(size_b);
        queue_frame_byte(type_b);
        case (cmd.kind)
            KIND_SET_FREQ: begin
                sum = sum + hi + lo;
                queue_stuffed_byte(hi);
                queue_stuffed_byte(lo);
                queue_stuffed_byte(sum);
            end
            KIND_GET_FREQ: queue_frame_byte(sum);
            default: begin
                sum = sum + lo;
                queue_frame_byte(lo);
                queue_stuffed_byte(sum);
            end
        endcase
        // Mark the final byte of this frame
        tail = frame_q.pop_back();
        tail.last_byte = 1'b1;
        frame_q.push_back(tail);
    endfunction

    function automatic t_dir_row dir_row(input logic [2:0] kind, input logic [15:0] value,
                                         input logic typed, input logic [3:0] nbytes,
                                         input logic [79:0] bytes);
        t_dir_row r;
        r.cmd.kind  = kind;
        r.cmd.value = value;
        r.typed     = typed;
        r.nbytes    = nbytes;
        r.bytes     = bytes;
        return r;
    endfunction

    // Offer one request after an optional gap; return at the accepting edge
    task automatic offer_command(input t_cmd_in cmd, input int gap);
        @(negedge i_clk);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push  <= 1'b1;
        i_cmd <= cmd;
        do @(posedge i_clk); while (full);
        accepted_cmds++;
    endtask

    // Check each popped frame byte against the oldest owed byte
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (frame_q.size() == 0) begin
                report_error($sformatf("unexpected frame byte %02h", o_frame.frame_byte));
            end else begin
                want = frame_q.pop_front();
                if (o_frame.frame_byte !== want.frame_byte) begin
                    report_error($sformatf("frame_byte %02h, want %02h",
                                           o_frame.frame_byte, want.frame_byte));
                end
                if (o_frame.last_byte !== want.last_byte) begin
                    report_error($sformatf("last_byte %b, want %b on byte %02h",
                                           o_frame.last_byte, want.last_byte, want.frame_byte));
                end
            end
        end
    end

    // Abort when no request moves on either side for too long
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Drive pop: random stalls, one long hold-off to back up the block
    initial begin : drive_pop
        int  hold;
        bit  pressed;
        hold    = 0;
        pressed = 1'b0;
        pop     = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!pressed && accepted_cmds >= PRESSURE_AT) begin
                pressed = 1'b1;
                hold    = PRESSURE_HOLD;
            end
            if (hold > 0) begin
                pop <= 1'b0;
                hold--;
            end else begin
                pop <= 1'b1;
                if (!steady && $urandom_range(0, 3) == 0) begin
                    hold = pick_gap();
                end
            end
        end
    end

    initial begin : drive_commands
        t_dir_row   row;
        t_frame_out f;
        t_cmd_in    cmd;
        logic [7:0] hi, lo, size_b, type_b;

        i_rst_n = 1'b0;
        push    = 1'b0;
        i_cmd   = '0;

        // Frames typed in: extremes, each kind, dropped kinds
        dir_rows.push_back(dir_row(KIND_GET_FREQ, 16'h0000, 1'b1, 4'd5,
                                   80'hAAFF010405_0000000000));
        dir_rows.push_back(dir_row(KIND_GET_FREQ, 16'hFFFF, 1'b1, 4'd5,
                                   80'hAAFF010405_0000000000));
        dir_rows.push_back(dir_row(KIND_SET_FREQ, 16'h0000, 1'b1, 4'd7,
                                   80'hAAFF0302000005_000000));
        dir_rows.push_back(dir_row(KIND_SET_FREQ, 16'hFFFF, 1'b1, 4'd7,
                                   80'hAAFF0302FFFF03_000000));
        dir_rows.push_back(dir_row(KIND_SET_ATT1, 16'h0000, 1'b1, 4'd6,
                                   80'hAAFF02030005_00000000));
        dir_rows.push_back(dir_row(KIND_SET_FILT, 16'h00FF, 1'b1, 4'd6,
                                   80'hAAFF0206FF07_00000000));
        dir_rows.push_back(dir_row(KIND_SET_ATT2, 16'hFF00, 1'b1, 4'd6,
                                   80'hAAFF02070009_00000000));
        dir_rows.push_back(dir_row(KIND_UNUSED_5, 16'hFFFF, 1'b1, 4'd0, '0));
        dir_rows.push_back(dir_row(KIND_UNUSED_6, 16'h0000, 1'b1, 4'd0, '0));
        dir_rows.push_back(dir_row(KIND_UNUSED_7, 16'h1234, 1'b1, 4'd0, '0));
        // Stuffed body bytes, checksums landing on reserved values, raw body bytes
        dir_rows.push_back(dir_row(KIND_SET_FREQ, 16'h5A55, 1'b0, 4'd0, '0));
        dir_rows.push_back(dir_row(KIND_SET_FREQ, 16'hA5AA, 1'b0, 4'd0, '0));
        dir_rows.push_back(dir_row(KIND_SET_FREQ, 16'h1095, 1'b0, 4'd0, '0));
        dir_rows.push_back(dir_row(KIND_SET_FREQ, 16'h2035, 1'b0, 4'd0, '0));
        dir_rows.push_back(dir_row(KIND_SET_FREQ, 16'hAA5A, 1'b0, 4'd0, '0));
        dir_rows.push_back(dir_row(KIND_SET_ATT1, 16'h0055, 1'b0, 4'd0, '0));
        dir_rows.push_back(dir_row(KIND_SET_ATT1, 16'hFFA0, 1'b0, 4'd0, '0));
        dir_rows.push_back(dir_row(KIND_SET_ATT2, 16'h00A1, 1'b0, 4'd0, '0));
        dir_rows.push_back(dir_row(KIND_SET_FILT, 16'h004D, 1'b0, 4'd0, '0));
        dir_rows.push_back(dir_row(KIND_SET_ATT1, 16'h12AA, 1'b0, 4'd0, '0));
        dir_rows.push_back(dir_row(KIND_SET_FILT, 16'hAB5A, 1'b0, 4'd0, '0));
        dir_rows.push_back(dir_row(KIND_GET_FREQ, 16'h5A5A, 1'b0, 4'd0, '0));

        // Hold reset, then release on a falling edge
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        foreach (dir_rows[n]) begin
            row = dir_rows[n];
            offer_command(row.cmd, pick_gap());
            if (row.typed) begin
                for (int i = 0; i < row.nbytes; i++) begin
                    f.frame_byte = row.bytes[79 - 8 * i -: 8];
                    f.last_byte  = (i == row.nbytes - 1);
                    frame_q.push_back(f);
                end
            end else begin
                expect_frame(row.cmd);
            end
        end

        // Random commands, mostly well-formed, some aimed at stuffing
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            steady   = (n >= STEADY_FIRST && n < STEADY_LAST);
            cmd.kind = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                   : 3'($urandom_range(0, 4));
            case ($urandom_range(0, 3))
                0, 1: cmd.value = 16'($urandom);
                2: begin
                    hi = ($urandom_range(0, 1) == 0) ? special_byte() : 8'($urandom);
                    lo = ($urandom_range(0, 1) == 0) ? special_byte() : 8'($urandom);
                    cmd.value = {hi, lo};
                end
                default: begin
                    // Aim the checksum at a reserved value
                    void'(kind_bytes(cmd.kind, size_b, type_b));
                    hi = 8'($urandom);
                    lo = special_byte() - (RCFE_ADDR + size_b + type_b + 8'd1);
                    if (cmd.kind == KIND_SET_FREQ) begin
                        lo = lo - hi;
                    end
                    cmd.value = {hi, lo};
                end
            endcase
            offer_command(cmd, steady ? 0 : pick_gap());
            expect_frame(cmd);
        end
        steady = 1'b0;

        @(negedge i_clk);
        push <= 1'b0;

        // Drain the owed bytes, then let the pipeline settle
        while (frame_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
